FILE: hw/rtl/sli_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sli_pkg
// Shared types and constants of the span list intersection block.
// ----------------------------------------------------------------------------
package sli_pkg;

  localparam int CLIP_DEPTH = 256;
  localparam int MAX_RUN    = 64;

  localparam int AddrW = $clog2(CLIP_DEPTH);
  localparam int PtrW  = $clog2(CLIP_DEPTH + 1);
  localparam int RunW  = $clog2(MAX_RUN + 1);
  // Wide enough for a 16-bit coordinate plus an offset plus a 16-bit length.
  localparam int CmpW  = 19;

  typedef enum logic [1:0] {
    REQ_APPEND = 2'd0,
    REQ_OBJECT = 2'd1,
    REQ_REWIND = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_e;

  typedef enum logic {
    CFG_OFFSET_X = 1'b0,
    CFG_OFFSET_Y = 1'b1
  } cfg_e;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [15:0] span_x;
    logic signed [15:0] span_y;
    logic [15:0]        span_len;
    logic [7:0]         span_coverage;
  } req_t;

  typedef struct packed {
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic [15:0]        out_len;
    logic [7:0]         out_coverage;
    logic               out_last;
    logic               out_truncated;
  } res_t;

  // One stored clip span, also the object span held during a walk.
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [15:0]        len;
    logic [7:0]         cov;
  } clip_t;

  // Verdict of comparing one clip entry against the current object span.
  typedef struct packed {
    logic        row_after;
    logic        row_before;
    logic        clip_before;
    logic        span_before;
    logic        nonzero;
    logic        span_ends_first;
    logic [15:0] ovl_x;
    logic [15:0] ovl_len;
    logic [7:0]  ovl_cov;
  } dec_t;

endpackage
`default_nettype wire

FILE: hw/rtl/sli_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sli_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sli_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: hw/rtl/sli_cmp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sli_cmp
// Compares one offset clip entry against the object span and forms the overlap.
// ----------------------------------------------------------------------------
module sli_cmp (
  input  wire sli_pkg::clip_t     span_i,
  input  wire sli_pkg::clip_t     entry_i,
  input  wire logic signed [15:0] off_x_i,
  input  wire logic signed [15:0] off_y_i,
  output      sli_pkg::dec_t      dec_o
);
  import sli_pkg::*;

  logic signed [CmpW-1:0] cy, sy, cx1, cx2, sx1, sx2, clen, slen;
  logic signed [CmpW-1:0] ox, oe, olen;
  logic [15:0]            prod;
  logic [16:0]            cov_sum;

  always_comb begin
    cy   = CmpW'(entry_i.y) + CmpW'(off_y_i);
    sy   = CmpW'(span_i.y);
    clen = CmpW'(entry_i.len);
    slen = CmpW'(span_i.len);
    cx1  = CmpW'(entry_i.x) + CmpW'(off_x_i);
    cx2  = cx1 + clen;
    sx1  = CmpW'(span_i.x);
    sx2  = sx1 + slen;
    ox   = (sx1 > cx1) ? sx1 : cx1;
    oe   = (sx2 < cx2) ? sx2 : cx2;
    olen = oe - ox;
  end

  // Coverage mix: (p + (p >> 8) + 0x80) >> 8, never above 255.
  always_comb begin
    prod    = 16'(span_i.cov * entry_i.cov);
    cov_sum = 17'(prod) + 17'(prod[15:8]) + 17'h80;
  end

  always_comb begin
    dec_o.row_after       = cy > sy;
    dec_o.row_before      = cy < sy;
    dec_o.clip_before     = (cx1 < sx1) && (cx2 < sx1);
    dec_o.span_before     = (sx1 < cx1) && (sx2 < cx1);
    dec_o.nonzero         = olen != '0;
    dec_o.span_ends_first = sx2 < cx2;
    dec_o.ovl_x           = ox[15:0];
    dec_o.ovl_len         = olen[15:0];
    dec_o.ovl_cov         = cov_sum[15:8];
  end

endmodule
`default_nettype wire

FILE: hw/rtl/span_list_intersect.sv
`default_nettype none
// ----------------------------------------------------------------------------
// span_list_intersect
// Intersects sorted object spans with a stored, offset list of clip spans.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on req_i when start is high and busy is low. Append stores
//   a clip span (ignored once the store is full), rewind resets the walk
//   pointer, clear empties the store; each is done in its accept cycle and gives nothing.
//   An object span walks the clip store from the kept pointer, one clip entry
//   per cycle, and emits one result transaction per overlap of nonzero length
//   on res_o, marked by res_valid_o for exactly one cycle. The receiver
//   cannot stall: every strobe is a transaction.
//   Timing of an object span: the first clip entry is read in the accept
//   cycle and arrives in the next. Busy then stays high through ST_EVAL,
//   which examines the clip entries, and through ST_FLUSH, which releases
//   the held last result. If the pointer already sits at the end of the
//   store, the span finishes in its accept cycle. Each result is held
//   until the next overlap is found, so that out_last can be set on the
//   final one: it leaves through the held and the output register, the
//   final one in the same cycle that busy drops.
//   At most MAX_RUN results per span; a longer run stops on the entry that
//   would have overflowed and flags out_truncated on its last result.
//   The user writes configuration (clip offsets) via cfg_we_i/cfg_idx_i only
//   while idle; the block does not enforce it. Reset clears the counters,
//   pointer and offsets, not the store; only entries below the count are read.
// ----------------------------------------------------------------------------
module span_list_intersect (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output      logic               busy,
  input  wire sli_pkg::req_t      req_i,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_idx_i,
  input  wire logic [15:0]        cfg_data_i,
  output      logic               res_valid_o,
  output      sli_pkg::res_t      res_o
);
  import sli_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_FLUSH
  } state_e;

  state_e             state_q, state_d;
  logic [PtrW-1:0]    count_q, count_d;
  logic [PtrW-1:0]    ptr_q, ptr_d;
  logic [PtrW-1:0]    ptr_inc;
  logic [RunW-1:0]    run_q, run_d;
  logic               cut_q, cut_d;
  logic signed [15:0] off_x_q, off_x_d;
  logic signed [15:0] off_y_q, off_y_d;
  clip_t              span_q, span_d;
  res_t               pend_q, pend_d;
  logic               pend_valid_q, pend_valid_d;
  res_t               res_q, res_d;
  logic               res_valid_q, res_valid_d;

  logic               accept;
  logic               ram_we;
  logic               ram_re;
  logic [AddrW-1:0]   ram_raddr;
  clip_t              ram_wdata;
  clip_t              entry;
  dec_t               dec;

  assign accept  = start && !busy;
  assign ptr_inc = ptr_q + 1'b1;

  // Appends write on the accept edge; a later walk reads only after it.
  assign ram_we    = accept && (req_i.req_type == REQ_APPEND) &&
                     (count_q < PtrW'(CLIP_DEPTH));
  assign ram_wdata = '{x: req_i.span_x, y: req_i.span_y,
                       len: req_i.span_len, cov: req_i.span_coverage};

  sli_ram #(
    .Width ($bits(clip_t)),
    .Depth (CLIP_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[AddrW-1:0]),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (entry)
  );

  sli_cmp u_cmp (
    .span_i  (span_q),
    .entry_i (entry),
    .off_x_i (off_x_q),
    .off_y_i (off_y_q),
    .dec_o   (dec)
  );

  always_comb begin
    logic stop, adv, emit, cut;

    state_d      = state_q;
    count_d      = count_q;
    ptr_d        = ptr_q;
    run_d        = run_q;
    cut_d        = cut_q;
    off_x_d      = off_x_q;
    off_y_d      = off_y_q;
    span_d       = span_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    res_d        = res_q;
    res_valid_d  = 1'b0;
    ram_re       = 1'b0;
    ram_raddr    = ptr_q[AddrW-1:0];
    stop         = 1'b0;
    adv          = 1'b0;
    emit         = 1'b0;
    cut          = 1'b0;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_OFFSET_X: off_x_d = cfg_data_i;
        CFG_OFFSET_Y: off_y_d = cfg_data_i;
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (req_i.req_type)
            REQ_APPEND: begin
              if (ram_we) begin
                count_d = count_q + 1'b1;
              end
            end
            REQ_OBJECT: begin
              span_d       = '{x: req_i.span_x, y: req_i.span_y,
                               len: req_i.span_len, cov: req_i.span_coverage};
              run_d        = '0;
              cut_d        = 1'b0;
              pend_valid_d = 1'b0;
              // Start a walk only when an entry is left to examine.
              if (ptr_q < count_q) begin
                ram_re    = 1'b1;
                ram_raddr = ptr_q[AddrW-1:0];
                state_d   = ST_EVAL;
              end
            end
            REQ_REWIND: begin
              ptr_d = '0;
            end
            REQ_CLEAR: begin
              ptr_d   = '0;
              count_d = '0;
            end
            default: ;
          endcase
        end
      end

      ST_EVAL: begin
        // Merge step against the entry at the pointer.
        if (dec.row_after) begin
          stop = 1'b1;
        end else if (dec.row_before || dec.clip_before) begin
          adv = 1'b1;
        end else if (dec.span_before) begin
          stop = 1'b1;
        end else begin
          if (dec.nonzero) begin
            if (run_q == RunW'(MAX_RUN)) begin
              cut  = 1'b1;
              stop = 1'b1;
            end else begin
              emit = 1'b1;
            end
          end
          if (!cut) begin
            if (dec.span_ends_first) begin
              stop = 1'b1;
            end else begin
              adv = 1'b1;
            end
          end
        end

        // Release the held result and hold the new one in its place.
        if (emit) begin
          if (pend_valid_q) begin
            res_d       = pend_q;
            res_valid_d = 1'b1;
          end
          pend_d       = '{out_x: dec.ovl_x, out_y: span_q.y, out_len: dec.ovl_len,
                           out_coverage: dec.ovl_cov, out_last: 1'b0,
                           out_truncated: 1'b0};
          pend_valid_d = 1'b1;
          run_d        = run_q + 1'b1;
        end

        if (cut) begin
          cut_d = 1'b1;
        end

        if (adv) begin
          ptr_d = ptr_inc;
          if (ptr_inc < count_q) begin
            ram_re    = 1'b1;
            ram_raddr = ptr_inc[AddrW-1:0];
          end else begin
            stop = 1'b1;
          end
        end

        if (stop) begin
          state_d = ST_FLUSH;
        end
      end

      ST_FLUSH: begin
        // Drop the final held result out, marked as last.
        if (pend_valid_q) begin
          res_d               = pend_q;
          res_d.out_last      = 1'b1;
          res_d.out_truncated = cut_q;
          res_valid_d         = 1'b1;
        end
        pend_valid_d = 1'b0;
        state_d      = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      ptr_q        <= '0;
      run_q        <= '0;
      cut_q        <= 1'b0;
      off_x_q      <= '0;
      off_y_q      <= '0;
      span_q       <= '0;
      pend_q       <= '0;
      pend_valid_q <= 1'b0;
      res_q        <= '0;
      res_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      ptr_q        <= ptr_d;
      run_q        <= run_d;
      cut_q        <= cut_d;
      off_x_q      <= off_x_d;
      off_y_q      <= off_y_d;
      span_q       <= span_d;
      pend_q       <= pend_d;
      pend_valid_q <= pend_valid_d;
      res_q        <= res_d;
      res_valid_q  <= res_valid_d;
    end
  end

  assign busy        = state_q != ST_IDLE;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // Truncation is only ever flagged on the closing result of a run.
  a_trunc_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.out_truncated |-> res_o.out_last)
    else $error("truncation flag on a result that is not last");

  // The walk pointer never passes the fill count of the store.
  a_ptr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= count_q)
    else $error("walk pointer beyond clip count");

  // Every evaluated entry is one that has been written.
  a_eval_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EVAL |-> ptr_q < count_q)
    else $error("evaluating an unwritten clip entry");

  // A run never exceeds its result budget.
  a_run_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q <= RunW'(MAX_RUN))
    else $error("run count above limit");

endmodule
`default_nettype wire
